/* rtl/segment_line_intersection_macros.svh */
// Assertion macros for the segment/line intersection block
`ifndef SEGMENT_LINE_INTERSECTION_MACROS_SVH
`define SEGMENT_LINE_INTERSECTION_MACROS_SVH

// implication in the same cycle, masked during reset
`define SLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sli check failed");

// implication into the next cycle, also checked through reset
`define SLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sli check failed");

`endif

/* rtl/sli_pkg.sv */
// Shared constants for the segment/line intersection block
package sli_pkg;
  localparam int COORD_BITS = 16;
  localparam int LIMIT_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEGMENT_MODE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PARALLEL_LIMIT = 1'b1;
  localparam logic SEGMENT_MODE_RESET = 1'b1;
  localparam logic [LIMIT_BITS-1:0] PARALLEL_LIMIT_RESET = 16'd1;
endpackage

/* rtl/sli_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
module sli_div #(
  parameter int NW = 54,
  parameter int QB = 17,
  parameter int SB = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  input  logic [SB-1:0] side_in,
  output logic [QB-1:0] q,
  output logic          ovf,
  output logic [SB-1:0] side_out
);
  logic [NW-1:0] rem    [0:QB];
  logic [NW-1:0] den_r  [0:QB];
  logic [QB-1:0] qr     [0:QB];
  logic          ovf_r  [0:QB];
  logic [SB-1:0] side_r [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num;
      den_r[0] <= den;
      qr[0]    <= '0;
      ovf_r[0] <= num >= (den << QB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_r[0] <= '0;
    end else if (en) begin
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int I = QB - k;
    logic [NW-1:0] dsh;
    logic          ge;
    logic [QB-1:0] qn;
    assign dsh = den_r[k-1] << I;
    assign ge  = rem[k-1] >= dsh;
    assign qn  = qr[k-1] | (QB'(ge) << I);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]    <= ge ? rem[k-1] - dsh : rem[k-1];
        den_r[k]  <= den_r[k-1];
        qr[k]     <= qn;
        ovf_r[k]  <= ovf_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign q        = qr[QB];
  assign ovf      = ovf_r[QB];
  assign side_out = side_r[QB];
endmodule

/* rtl/segment_line_intersection.sv */
// Top level of the pipelined 2-D segment/line intersection block
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | a_x a_y b_x b_y c_x c_y d_x d_y
//  out     | output    | out_valid / out_stall | hit point_x point_y saturated
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One transaction per cycle sustained while no result waits under out_stall.
// The divider produces one quotient bit per stage.
// The whole pipeline holds while a result waits under out_stall.
// Synchronous reset clears the valid bits and loads the two registers with their reset values.
module segment_line_intersection #(
  parameter int COORD_BITS = sli_pkg::COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          a_x,
  input  logic signed [COORD_BITS-1:0]          a_y,
  input  logic signed [COORD_BITS-1:0]          b_x,
  input  logic signed [COORD_BITS-1:0]          b_y,
  input  logic signed [COORD_BITS-1:0]          c_x,
  input  logic signed [COORD_BITS-1:0]          c_y,
  input  logic signed [COORD_BITS-1:0]          d_x,
  input  logic signed [COORD_BITS-1:0]          d_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  hit,
  output logic signed [COORD_BITS-1:0]          point_x,
  output logic signed [COORD_BITS-1:0]          point_y,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sli_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [sli_pkg::LIMIT_BITS-1:0]        cfg_data
);
  localparam int W    = COORD_BITS;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * W + 2;
  localparam int CW   = 2 * W + 3;
  localparam int NUMW = 3 * W + 4;
  localparam int NW   = 3 * W + 6;
  localparam int QB   = W + 1;
  localparam int SW   = W + 3;
  localparam int SBX  = W + 3;
  localparam int SBY  = W + 1;

  logic segment_mode;
  logic [sli_pkg::LIMIT_BITS-1:0] parallel_limit;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode   <= sli_pkg::SEGMENT_MODE_RESET;
      parallel_limit <= sli_pkg::PARALLEL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sli_pkg::REG_SEGMENT_MODE:   segment_mode   <= cfg_data[0];
        sli_pkg::REG_PARALLEL_LIMIT: parallel_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences
  logic v1;
  logic signed [W-1:0]  ax1, ay1;
  logic signed [DW-1:0] abx1, aby1, cdx1, cdy1, acx1, acy1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1  <= a_x;
      ay1  <= a_y;
      abx1 <= DW'(b_x) - DW'(a_x);
      aby1 <= DW'(b_y) - DW'(a_y);
      cdx1 <= DW'(d_x) - DW'(c_x);
      cdy1 <= DW'(d_y) - DW'(c_y);
      acx1 <= DW'(c_x) - DW'(a_x);
      acy1 <= DW'(c_y) - DW'(a_y);
    end
  end

  // stage 2: products
  logic v2;
  logic signed [W-1:0]  ax2, ay2;
  logic signed [DW-1:0] abx2, aby2;
  logic signed [PW-1:0] pd1, pd2, pt1, pt2, pu1, pu2;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2  <= ax1;
      ay2  <= ay1;
      abx2 <= abx1;
      aby2 <= aby1;
      pd1  <= PW'(abx1) * PW'(cdy1);
      pd2  <= PW'(aby1) * PW'(cdx1);
      pt1  <= PW'(acx1) * PW'(cdy1);
      pt2  <= PW'(acy1) * PW'(cdx1);
      pu1  <= PW'(acx1) * PW'(aby1);
      pu2  <= PW'(acy1) * PW'(abx1);
    end
  end

  // stage 3: cross products
  logic v3;
  logic signed [W-1:0]  ax3, ay3;
  logic signed [DW-1:0] abx3, aby3;
  logic signed [CW-1:0] d3, tn3, un3;

  always_ff @(posedge clk) begin
    if (en) begin
      ax3  <= ax2;
      ay3  <= ay2;
      abx3 <= abx2;
      aby3 <= aby2;
      d3   <= CW'(pd1) - CW'(pd2);
      tn3  <= CW'(pt1) - CW'(pt2);
      un3  <= CW'(pu1) - CW'(pu2);
    end
  end

  // stage 4: hit decision, point numerators
  logic [CW-1:0] dabs3, tabs3, uabs3;
  logic          tin3, uin3, hit3;

  assign dabs3 = d3[CW-1]  ? CW'(-d3)  : CW'(d3);
  assign tabs3 = tn3[CW-1] ? CW'(-tn3) : CW'(tn3);
  assign uabs3 = un3[CW-1] ? CW'(-un3) : CW'(un3);
  assign tin3  = (tn3 == '0) || ((tn3[CW-1] == d3[CW-1]) && (tabs3 <= dabs3));
  assign uin3  = (un3 == '0) || ((un3[CW-1] == d3[CW-1]) && (uabs3 <= dabs3));
  assign hit3  = (d3 != '0) && (dabs3 >= CW'(parallel_limit))
                 && (!segment_mode || (tin3 && uin3));

  logic v4, hit4, dneg4;
  logic signed [W-1:0]    ax4, ay4;
  logic [CW-1:0]          dabs4;
  logic signed [NUMW-1:0] nx4, ny4;

  always_ff @(posedge clk) begin
    if (en) begin
      ax4   <= ax3;
      ay4   <= ay3;
      hit4  <= hit3;
      dneg4 <= d3[CW-1];
      dabs4 <= dabs3;
      nx4   <= NUMW'(tn3) * NUMW'(abx3);
      ny4   <= NUMW'(tn3) * NUMW'(aby3);
    end
  end

  // stage 5: rounding numerator and denominator
  logic [NUMW-1:0] nxabs4, nyabs4;
  assign nxabs4 = nx4[NUMW-1] ? NUMW'(-nx4) : NUMW'(nx4);
  assign nyabs4 = ny4[NUMW-1] ? NUMW'(-ny4) : NUMW'(ny4);

  logic v5, hit5, negx5, negy5;
  logic signed [W-1:0] ax5, ay5;
  logic [NW-1:0]       numx5, numy5, den5;

  always_ff @(posedge clk) begin
    if (en) begin
      ax5   <= ax4;
      ay5   <= ay4;
      hit5  <= hit4;
      negx5 <= nx4[NUMW-1] ^ dneg4;
      negy5 <= ny4[NUMW-1] ^ dneg4;
      numx5 <= (NW'(nxabs4) << 1) + NW'(dabs4);
      numy5 <= (NW'(nyabs4) << 1) + NW'(dabs4);
      den5  <= NW'(dabs4) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // dividers
  logic [QB-1:0]  qx, qy;
  logic           ovfx, ovfy;
  logic [SBX-1:0] sidex;
  logic [SBY-1:0] sidey;

  sli_div #(.NW(NW), .QB(QB), .SB(SBX)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (numx5),
    .den      (den5),
    .side_in  ({v5, hit5, negx5, ax5}),
    .q        (qx),
    .ovf      (ovfx),
    .side_out (sidex)
  );

  sli_div #(.NW(NW), .QB(QB), .SB(SBY)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (numy5),
    .den      (den5),
    .side_in  ({negy5, ay5}),
    .q        (qy),
    .ovf      (ovfy),
    .side_out (sidey)
  );

  // output stage: add base, saturate
  logic                vq, hitq, negxq, negyq;
  logic signed [W-1:0] axq, ayq;
  logic signed [SW-1:0] qxs, qys, sx, sy;
  logic signed [SW-1:0] hib, lob;
  logic signed [W-1:0]  px, py;
  logic                 satx, saty;

  assign {vq, hitq, negxq, axq} = sidex;
  assign {negyq, ayq}           = sidey;
  assign hib = SW'({1'b0, {(W-1){1'b1}}});
  assign lob = -hib - SW'(1);
  assign qxs = $signed({2'b00, qx});
  assign qys = $signed({2'b00, qy});
  assign sx  = SW'(axq) + (negxq ? -qxs : qxs);
  assign sy  = SW'(ayq) + (negyq ? -qys : qys);

  always_comb begin
    satx = 1'b1;
    if (ovfx) begin
      px = negxq ? W'(lob) : W'(hib);
    end else if (sx > hib) begin
      px = W'(hib);
    end else if (sx < lob) begin
      px = W'(lob);
    end else begin
      px   = W'(sx);
      satx = 1'b0;
    end
  end

  always_comb begin
    saty = 1'b1;
    if (ovfy) begin
      py = negyq ? W'(lob) : W'(hib);
    end else if (sy > hib) begin
      py = W'(hib);
    end else if (sy < lob) begin
      py = W'(lob);
    end else begin
      py   = W'(sy);
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit       <= hitq;
      point_x   <= hitq ? px : '0;
      point_y   <= hitq ? py : '0;
      saturated <= hitq && (satx || saty);
    end
  end
endmodule

/* rtl/sli_check.sv */
// Port-level checker for the intersection block, bound to the top level
`include "segment_line_intersection_macros.svh"

module sli_check #(
  parameter int COORD_BITS = sli_pkg::COORD_BITS
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               hit,
  input logic signed [COORD_BITS-1:0]       point_x,
  input logic signed [COORD_BITS-1:0]       point_y,
  input logic                               saturated
);
  `SLI_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
  `SLI_ASSERT_NOW(a_miss_is_zero, out_valid && !hit, point_x == '0 && point_y == '0 && !saturated)
  `SLI_ASSERT_NEXT(a_reset_empties, rst, !out_valid)
  `SLI_ASSERT_NOW(a_held_result, out_valid && out_stall, 1'b1 ##1 out_valid)
endmodule

bind segment_line_intersection sli_check #(.COORD_BITS(COORD_BITS)) u_sli_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .point_x   (point_x),
  .point_y   (point_y),
  .saturated (saturated)
);
